// ----- rtl/tbs_pkg.sv -----
package tbs_pkg;

  // Input and output field widths.
  localparam int unsigned ReW   = 21;
  localparam int unsigned RateW = 12;
  localparam int unsigned TbsW  = 22;

  // Product of the two inputs, 11 fraction bits.
  localparam int unsigned ProdW = 33;
  localparam int unsigned FracW = 11;

  // Quantized information bit count and derived widths.
  localparam int unsigned QW    = 23;
  localparam int unsigned SmallW = 12;
  localparam int unsigned X8W   = 20;
  localparam int unsigned CW    = 11;

  // Restoring divider widths.
  localparam int unsigned DIV_NW = 23;
  localparam int unsigned DIV_DW = 14;

  // Queue between front and back.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  // Rule constants.
  localparam logic [QW-1:0]    SmallLimit  = QW'(3824);
  localparam logic [QW-1:0]    LargeFloor  = QW'(3840);
  localparam logic [QW-1:0]    CbLowRate   = QW'(3816);
  localparam logic [QW-1:0]    CbHighRate  = QW'(8424);
  localparam logic [RateW-1:0] RateQuarter = RateW'(512);
  localparam logic [QW-1:0]    CrcLen      = QW'(24);
  localparam logic [TbsW-1:0]  OutMax      = '1;

  // Code block sizes over eight and their reciprocals scaled by 2^RecipK.
  // The estimate from the reciprocal is at most one below the true quotient.
  localparam int unsigned       RecipK      = 30;
  localparam int unsigned       RecipW      = 22;
  localparam logic [CW-1:0]     CbLowStep   = CW'(CbLowRate >> 3);
  localparam logic [CW-1:0]     CbHighStep  = CW'(CbHighRate >> 3);
  localparam logic [RecipW-1:0] CbLowRecip  = RecipW'((64'd1 << RecipK) / 64'(CbLowStep));
  localparam logic [RecipW-1:0] CbHighRecip = RecipW'((64'd1 << RecipK) / 64'(CbHighStep));

  localparam int unsigned TableLen = 93;

  // Allowed sizes for small information bit counts.
  localparam logic [SmallW-1:0] SIZE_TABLE [TableLen] = '{
    12'd24,   12'd32,   12'd40,   12'd48,   12'd56,   12'd64,   12'd72,   12'd80,
    12'd88,   12'd96,   12'd104,  12'd112,  12'd120,  12'd128,  12'd136,  12'd144,
    12'd152,  12'd160,  12'd168,  12'd176,  12'd184,  12'd192,  12'd208,  12'd224,
    12'd240,  12'd256,  12'd272,  12'd288,  12'd304,  12'd320,  12'd336,  12'd352,
    12'd368,  12'd384,  12'd408,  12'd432,  12'd456,  12'd480,  12'd504,  12'd528,
    12'd552,  12'd576,  12'd608,  12'd640,  12'd672,  12'd704,  12'd736,  12'd768,
    12'd808,  12'd848,  12'd888,  12'd928,  12'd984,  12'd1032, 12'd1064, 12'd1128,
    12'd1160, 12'd1192, 12'd1224, 12'd1256, 12'd1288, 12'd1320, 12'd1352, 12'd1416,
    12'd1480, 12'd1544, 12'd1608, 12'd1672, 12'd1736, 12'd1800, 12'd1864, 12'd1928,
    12'd2024, 12'd2088, 12'd2152, 12'd2216, 12'd2280, 12'd2408, 12'd2472, 12'd2536,
    12'd2600, 12'd2664, 12'd2728, 12'd2792, 12'd2856, 12'd2976, 12'd3104, 12'd3240,
    12'd3368, 12'd3496, 12'd3624, 12'd3752, 12'd3824
  };

  // How the code block count is formed.
  typedef enum logic [1:0] {
    CbOne,
    CbLow,
    CbHigh
  } cb_mode_e;

  // Word handed from the front to the back through the queue.
  typedef struct packed {
    logic              is_small;
    logic [SmallW-1:0] tbs_small;
    cb_mode_e          cb_mode;
    logic [X8W-1:0]    cb_num;
    logic [X8W-1:0]    x8;
  } tbs_ent_t;

  // Sideband that travels along the back pipeline.
  typedef struct packed {
    logic              is_small;
    logic [SmallW-1:0] tbs_small;
    logic [X8W-1:0]    x8;
    logic [CW-1:0]     c;
  } tbs_side_t;

  // Smallest table entry at or above q.
  function automatic logic [SmallW-1:0] tbs_lookup(input logic [SmallW-1:0] q);
    logic [SmallW-1:0] r;
    r = SIZE_TABLE[TableLen-1];
    for (int i = TableLen - 1; i >= 0; i--) begin
      if (SIZE_TABLE[i] >= q) begin
        r = SIZE_TABLE[i];
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/tbs_fifo.sv -----
module tbs_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tbs_pkg::tbs_ent_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output tbs_pkg::tbs_ent_t pop_data_o,
  output logic              empty_o
);
  import tbs_pkg::*;

  tbs_ent_t          mem_q [QDepth];
  logic [QPtrW-1:0]  wr_q, wr_d;
  logic [QPtrW-1:0]  rd_q, rd_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;

  assign full_o     = (cnt_q == QCntW'(QDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  // Pointer and fill count update.
  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + QCntW'(push_i) - QCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into a full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from an empty queue");

endmodule

// ----- rtl/tbs_front.sv -----
module tbs_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [tbs_pkg::ReW-1:0]    re_times_qm_i,
  input  logic [tbs_pkg::RateW-1:0]  code_rate_x2048_i,
  output logic                       push_o,
  output tbs_pkg::tbs_ent_t          push_data_o,
  input  logic                       full_i
);
  import tbs_pkg::*;

  // Position of the highest set bit.
  function automatic logic [5:0] top_bit(input logic [ProdW-1:0] v);
    logic [5:0] pos;
    pos = '0;
    for (int i = 0; i < ProdW; i++) begin
      if (v[i]) begin
        pos = 6'(i);
      end
    end
    return pos;
  endfunction

  logic fadv;

  logic             v1_q, v2_q, v3_q, v4_q;
  logic [ProdW-1:0] p1_q;
  logic             low1_q, low2_q, low3_q;
  logic             small2_q, small3_q;
  logic [ProdW-1:0] val2_q;
  logic [5:0]       msb2_q;
  logic [QW-1:0]    q3_q;
  tbs_ent_t         ent4_q;

  logic [ProdW-1:0] prod_w;
  logic [ProdW-1:0] pc_w, m_w;
  logic             small_w;
  logic [5:0]       lg_w, ns_w, shs_w, shl_w;
  logic [QW-1:0]    qs_w, ql_w, q_w;
  logic [ProdW:0]   sum_w;
  logic [QW-1:0]    x_w;
  logic [X8W-1:0]   x8_w;
  tbs_ent_t         ent_w;

  // The front moves as a whole unless its last stage cannot enter the queue.
  assign fadv       = !v4_q || !full_i;
  assign in_ready_o = fadv;
  assign push_o     = v4_q && !full_i;
  assign push_data_o = ent4_q;

  assign prod_w = re_times_qm_i * code_rate_x2048_i;

  // Floor the product at one and pick the small or the large rule.
  always_comb begin
    pc_w    = (p1_q < (ProdW'(1) << FracW)) ? (ProdW'(1) << FracW) : p1_q;
    small_w = (pc_w <= (ProdW'(SmallLimit) << FracW));
    m_w     = pc_w - (ProdW'(CrcLen) << FracW);
  end

  // Quantize the information bit count.
  always_comb begin
    lg_w  = msb2_q - 6'(FracW);
    ns_w  = (lg_w >= 6'd9) ? lg_w - 6'd6 : 6'd3;
    shs_w = 6'(FracW) + ns_w;
    qs_w  = QW'((val2_q >> shs_w) << ns_w);
    if (qs_w < CrcLen) begin
      qs_w = CrcLen;
    end
    // Round half away from zero to a step of 2^(msb-16).
    shl_w = msb2_q - 6'd5;
    sum_w = {1'b0, val2_q} + ((ProdW + 1)'(1) << (msb2_q - 6'd6));
    ql_w  = QW'((sum_w >> shl_w) << (msb2_q - 6'd16));
    if (ql_w < LargeFloor) begin
      ql_w = LargeFloor;
    end
    q_w = small2_q ? qs_w : ql_w;
  end

  // Table lookup and code block count setup. The size plus the CRC is a
  // multiple of eight on the large path, so the count works on it over eight.
  always_comb begin
    x_w             = q3_q + CrcLen;
    x8_w            = X8W'(x_w >> 3);
    ent_w.is_small  = small3_q;
    ent_w.tbs_small = tbs_lookup(q3_q[SmallW-1:0]);
    ent_w.x8        = x8_w;
    if (small3_q) begin
      ent_w.cb_mode = CbOne;
      ent_w.cb_num  = '0;
    end else if (low3_q) begin
      ent_w.cb_mode = CbLow;
      ent_w.cb_num  = x8_w + X8W'(CbLowStep) - 1'b1;
    end else if (q3_q > CbHighRate) begin
      ent_w.cb_mode = CbHigh;
      ent_w.cb_num  = x8_w + X8W'(CbHighStep) - 1'b1;
    end else begin
      ent_w.cb_mode = CbOne;
      ent_w.cb_num  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (fadv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fadv) begin
      p1_q     <= prod_w;
      low1_q   <= (code_rate_x2048_i <= RateQuarter);
      low2_q   <= low1_q;
      small2_q <= small_w;
      val2_q   <= small_w ? pc_w : m_w;
      msb2_q   <= top_bit(small_w ? pc_w : m_w);
      low3_q   <= low2_q;
      small3_q <= small2_q;
      q3_q     <= q_w;
      ent4_q   <= ent_w;
    end
  end

endmodule

// ----- rtl/tbs_div.sv -----
module tbs_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [tbs_pkg::DIV_NW-1:0]  num_i,
  input  logic [tbs_pkg::DIV_DW-1:0]  den_i,
  input  tbs_pkg::tbs_side_t          side_i,
  output logic                        valid_o,
  output logic [tbs_pkg::DIV_NW-1:0]  quo_o,
  output tbs_pkg::tbs_side_t          side_o
);
  import tbs_pkg::*;

  logic              v_q    [DIV_NW];
  logic [DIV_DW-1:0] rem_q  [DIV_NW];
  logic [DIV_NW-1:0] num_q  [DIV_NW];
  logic [DIV_NW-1:0] quo_q  [DIV_NW];
  logic [DIV_DW-1:0] den_q  [DIV_NW];
  tbs_side_t         side_q [DIV_NW];

  logic [DIV_DW-1:0] pr   [DIV_NW];
  logic [DIV_NW-1:0] pn   [DIV_NW];
  logic [DIV_NW-1:0] pq   [DIV_NW];
  logic [DIV_DW-1:0] pd   [DIV_NW];
  logic [DIV_DW:0]   t    [DIV_NW];
  logic [DIV_DW-1:0] rem_d [DIV_NW];
  logic [DIV_NW-1:0] quo_d [DIV_NW];

  // One quotient bit per stage, most significant first.
  always_comb begin
    pr[0] = '0;
    pn[0] = num_i;
    pq[0] = '0;
    pd[0] = den_i;
    for (int s = 1; s < DIV_NW; s++) begin
      pr[s] = rem_q[s-1];
      pn[s] = num_q[s-1];
      pq[s] = quo_q[s-1];
      pd[s] = den_q[s-1];
    end
    for (int s = 0; s < DIV_NW; s++) begin
      t[s] = {pr[s], pn[s][DIV_NW-1]};
      if (t[s] >= {1'b0, pd[s]}) begin
        rem_d[s] = DIV_DW'(t[s] - {1'b0, pd[s]});
        quo_d[s] = {pq[s][DIV_NW-2:0], 1'b1};
      end else begin
        rem_d[s] = t[s][DIV_DW-1:0];
        quo_d[s] = {pq[s][DIV_NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DIV_NW; s++) begin
        v_q[s] <= 1'b0;
      end
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int s = 1; s < DIV_NW; s++) begin
        v_q[s] <= v_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int s = 1; s < DIV_NW; s++) begin
        side_q[s] <= side_q[s-1];
      end
      for (int s = 0; s < DIV_NW; s++) begin
        rem_q[s] <= rem_d[s];
        num_q[s] <= {pn[s][DIV_NW-2:0], 1'b0};
        quo_q[s] <= quo_d[s];
        den_q[s] <= pd[s];
      end
    end
  end

  assign valid_o = v_q[DIV_NW-1];
  assign quo_o   = quo_q[DIV_NW-1];
  assign side_o  = side_q[DIV_NW-1];

endmodule

// ----- rtl/tbs_back.sv -----
module tbs_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  tbs_pkg::tbs_ent_t        head_i,
  input  logic                     empty_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [tbs_pkg::TbsW-1:0] tbs_bits_o
);
  import tbs_pkg::*;

  logic                  badv;
  tbs_side_t             side0_w, side1c_w, side2_w;
  logic [RecipW-1:0]     recip_w;
  logic [X8W+RecipW-1:0] est_w;
  logic [CW-1:0]         step_w;
  logic [X8W-1:0]        rem_w;
  logic [CW-1:0]         c_w;
  logic                  v2_w;
  logic [DIV_NW-1:0]     num2_w, quo2_w;

  logic              cb1_v_q, cb2_v_q;
  tbs_side_t         cb1_side_q, cb2_side_q;
  cb_mode_e          cb1_mode_q;
  logic [X8W-1:0]    cb1_num_q;
  logic [CW-1:0]     cb1_qe_q;

  logic              vm_q, out_v_q;
  logic              smallm_q;
  logic [SmallW-1:0] tbs_smallm_q;
  logic [X8W:0]      prod_q;
  logic [TbsW-1:0]   tbs_q;
  logic [TbsW+1:0]   big_w;
  logic [TbsW-1:0]   tbs_w;

  // The back advances whenever the output register is free or being emptied.
  assign badv  = !out_v_q || out_ready_i;
  assign pop_o = badv && !empty_i;

  always_comb begin
    side0_w.is_small  = head_i.is_small;
    side0_w.tbs_small = head_i.tbs_small;
    side0_w.x8        = head_i.x8;
    side0_w.c         = '0;
  end

  // Code block count estimate by reciprocal multiplication.
  always_comb begin
    unique case (head_i.cb_mode)
      CbLow:   recip_w = CbLowRecip;
      CbHigh:  recip_w = CbHighRecip;
      default: recip_w = '0;
    endcase
    est_w = (X8W + RecipW)'(head_i.cb_num) * (X8W + RecipW)'(recip_w);
  end

  // Correct the estimate by one where the remainder still covers a step.
  always_comb begin
    unique case (cb1_mode_q)
      CbLow:   step_w = CbLowStep;
      CbHigh:  step_w = CbHighStep;
      default: step_w = CW'(1);
    endcase
    rem_w = cb1_num_q - X8W'(cb1_qe_q) * X8W'(step_w);
    if (cb1_mode_q == CbOne) begin
      c_w = CW'(1);
    end else if (rem_w >= X8W'(step_w)) begin
      c_w = cb1_qe_q + 1'b1;
    end else begin
      c_w = cb1_qe_q;
    end
    side1c_w   = cb1_side_q;
    side1c_w.c = c_w;
  end

  // Ceiling of x/8 over the code block count.
  always_comb begin
    num2_w = DIV_NW'(cb2_side_q.x8) + DIV_NW'(cb2_side_q.c) - 1'b1;
  end

  tbs_div u_div_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (badv),
    .valid_i (cb2_v_q),
    .num_i   (num2_w),
    .den_i   (DIV_DW'(cb2_side_q.c)),
    .side_i  (cb2_side_q),
    .valid_o (v2_w),
    .quo_o   (quo2_w),
    .side_o  (side2_w)
  );

  // Final size: the table value on the small path, else 8 * C * ceil, minus the CRC, saturated.
  always_comb begin
    big_w = {prod_q, 3'b000} - (TbsW + 2)'(CrcLen);
    if (smallm_q) begin
      tbs_w = TbsW'(tbs_smallm_q);
    end else if (big_w > (TbsW + 2)'(OutMax)) begin
      tbs_w = OutMax;
    end else begin
      tbs_w = big_w[TbsW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cb1_v_q <= 1'b0;
      cb2_v_q <= 1'b0;
      vm_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (badv) begin
      cb1_v_q <= pop_o;
      cb2_v_q <= cb1_v_q;
      vm_q    <= v2_w;
      out_v_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (badv) begin
      cb1_side_q   <= side0_w;
      cb1_mode_q   <= head_i.cb_mode;
      cb1_num_q    <= head_i.cb_num;
      cb1_qe_q     <= est_w[RecipK +: CW];
      cb2_side_q   <= side1c_w;
      smallm_q     <= side2_w.is_small;
      tbs_smallm_q <= side2_w.tbs_small;
      prod_q       <= (X8W + 1)'(side2_w.c) * (X8W + 1)'(quo2_w[X8W-1:0]);
      tbs_q        <= tbs_w;
    end
  end

  assign out_valid_o = out_v_q;
  assign tbs_bits_o  = tbs_q;

  a_min_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (tbs_q >= TbsW'(CrcLen)))
    else $error("size below the CRC length");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_ready_i) |=> (out_v_q && $stable(tbs_q)))
    else $error("output word changed while stalled");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !empty_i)
    else $error("pop while the queue is empty");

endmodule

// ----- rtl/nr_transport_block_size.sv -----
// Channel   Handshake                   Word
// -------   -------------------------   -----------------------------------
// in        in_valid_i / in_ready_o     re_times_qm_i, code_rate_x2048_i
// out       out_valid_o / out_ready_i   tbs_bits_o
//
// One word per cycle in steady state while the output is not stalled; a word
// passes through the 4-stage front, the queue, the 2-stage code block count,
// the 23-stage restoring divider and 2 output stages.
// A 4-word queue parts the front (multiply, quantize, table) from the back.
// Reset is asynchronous, active low, and clears all valid flags and pointers.
// A stalled output freezes the back; the front keeps taking words until the
// queue fills.
module nr_transport_block_size (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [tbs_pkg::ReW-1:0]     re_times_qm_i,
  input  logic [tbs_pkg::RateW-1:0]   code_rate_x2048_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tbs_pkg::TbsW-1:0]    tbs_bits_o
);
  import tbs_pkg::*;

  logic     push, full, pop, empty;
  tbs_ent_t push_data, head;

  tbs_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .re_times_qm_i     (re_times_qm_i),
    .code_rate_x2048_i (code_rate_x2048_i),
    .push_o            (push),
    .push_data_o       (push_data),
    .full_i            (full)
  );

  tbs_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (head),
    .empty_o     (empty)
  );

  tbs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .tbs_bits_o  (tbs_bits_o)
  );

endmodule
